// ===== sv/ggm_prf_eval_core_defines.svh =====
// Assertion macros used by the checker file
`ifndef GGM_PRF_EVAL_CORE_DEFINES_SVH
`define GGM_PRF_EVAL_CORE_DEFINES_SVH
// Implication check under synchronous reset
`define GGM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check under synchronous reset
`define GGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== sv/ggm_pkg.sv =====
`default_nettype none
package ggm_pkg;
   localparam int unsigned WordBits = 64;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1,
      CSR_DEPTH    = 2'd2,
      CSR_LIMIT    = 2'd3
   } csr_index_type;

   // Job handed from front to back
   typedef struct packed {
      logic [31:0] point;
      logic [5:0]  depth;
      logic        bad;
   } job_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit block sits at bits [127-8i -: 8]
   function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   // One AES round on state s with round key k; last skips MixColumns
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] k,
                                              input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[r + 4*c] = sbox(byte_at(s, r + 4*((c + r) % 4)));
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
      return o ^ k;
   endfunction

   // Next round key from previous one and round constant
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;  4'd2: v = 8'h02;  4'd3: v = 8'h04;  4'd4: v = 8'h08;
         4'd5: v = 8'h10;  4'd6: v = 8'h20;  4'd7: v = 8'h40;  4'd8: v = 8'h80;
         4'd9: v = 8'h1b;  4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== sv/ggm_front.sv =====
`default_nettype none
module ggm_front #(
   parameter int unsigned MAX_DEPTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [31:0]       req_point,
   input  wire logic [5:0]        depth_cfg,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output ggm_pkg::job_type       job
);
   import ggm_pkg::*;

   localparam int Entries = 2;
   job_type    q_ff [Entries];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [5:0] dep;
   job_type    nj;
   logic       push, pop;

   // Saturate depth and classify the point
   always_comb begin
      dep = (depth_cfg > 6'(MAX_DEPTH)) ? 6'(MAX_DEPTH) : depth_cfg;
      nj.point = req_point;
      nj.depth = dep;
      nj.bad = (dep < 6'd32) && ((req_point >> dep) != 32'd0);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ pop;
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= nj;
   end
endmodule
`default_nettype wire

// ===== sv/ggm_back.sv =====
`default_nettype none
module ggm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire ggm_pkg::job_type  job,
   input  wire logic [127:0]      root_key,
   input  wire logic [31:0]       limit_cfg,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [31:0]            rsp_prf_value,
   output logic                   rsp_bad_point
);
   import ggm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LEFT  = 6'b000010,
      ST_RIGHT = 6'b000100,
      ST_NEXT  = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type    st_ff, st_in;
   logic [127:0] label_ff, label_in, rk_ff, rk_in, s_ff, s_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [5:0]   lvl_ff, lvl_in, depth_ff, depth_in;
   logic [31:0]  point_ff, point_in, res_ff, res_in;
   logic         bad_ff, bad_in, vld_ff, vld_in;
   logic [31:0]  out_value_ff, out_value_in;
   logic         out_bad_ff, out_bad_in;
   logic [6:0]   sh_ff, sh_in;
   logic [63:0]  mask, win;
   logic [127:0] rnd_out, rk_next;
   logic         bit_sel;

   assign job_ready = st_ff == ST_IDLE;
   assign rsp_valid = vld_ff;
   assign rsp_prf_value = out_value_ff;
   assign rsp_bad_point = out_bad_ff;

   always_comb begin
      rk_next = key_step(rk_ff, rcon(rnd_ff));
      rnd_out = aes_round(s_ff, rk_next, rnd_ff == 4'd10);
      bit_sel = point_ff[5'(depth_ff - lvl_ff - 6'd1)];
      mask = (64'd1 << depth_ff) - 64'd1;
      win = (label_ff[127:64] >> sh_ff[5:0]) & mask;
   end

   // Level walk, leaf scan and response: ten rounds per encryption, key schedule alongside
   always_comb begin
      st_in = st_ff; label_in = label_ff; rk_in = rk_ff; s_in = s_ff;
      rnd_in = rnd_ff; lvl_in = lvl_ff; depth_in = depth_ff;
      point_in = point_ff; res_in = res_ff; bad_in = bad_ff; vld_in = vld_ff;
      out_value_in = out_value_ff; out_bad_in = out_bad_ff;
      sh_in = sh_ff;
      if (rsp_valid && rsp_ready) vld_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               point_in = job.point; depth_in = job.depth; bad_in = job.bad;
               label_in = root_key; lvl_in = '0; sh_in = '0; res_in = '0;
               st_in = job.bad ? ST_OUT : ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (lvl_ff == depth_ff) st_in = ST_SCAN;
            else begin
               // Label encrypted under itself: first round key cancels the block
               rk_in = label_ff; s_in = 128'd0; rnd_in = 4'd1;
               st_in = ST_LEFT;
            end
         end
         ST_LEFT: begin
            // rk_ff holds previous round key; s_ff the state after that round
            s_in = rnd_out; rk_in = rk_next; rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'd10) begin
               if (!bit_sel) begin
                  label_in = rnd_out; lvl_in = lvl_ff + 6'd1; st_in = ST_NEXT;
               end else begin
                  rk_in = label_ff; rnd_in = 4'd1;
                  s_in = label_ff ^ rnd_out ^ label_ff;
                  st_in = ST_RIGHT;
               end
            end
         end
         ST_RIGHT: begin
            s_in = rnd_out; rk_in = rk_next; rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'd10) begin
               label_in = rnd_out; lvl_in = lvl_ff + 6'd1; st_in = ST_NEXT;
            end
         end
         ST_SCAN: begin
            if (win < {32'd0, limit_cfg}) begin
               res_in = win[31:0]; st_in = ST_OUT;
            end else if (sh_ff == 7'd63) begin
               res_in = '0; st_in = ST_OUT;
            end else sh_in = sh_ff + 7'd1;
         end
         ST_OUT: begin
            // Load the response register once the previous response has left
            if (!vld_in) begin
               vld_in = 1'b1; st_in = ST_IDLE;
               out_value_in = bad_ff ? 32'd0 : res_ff;
               out_bad_in = bad_ff;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         vld_ff <= vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      label_ff <= label_in; rk_ff <= rk_in; s_ff <= s_in;
      rnd_ff <= rnd_in; lvl_ff <= lvl_in; depth_ff <= depth_in;
      point_ff <= point_in; res_ff <= res_in; bad_ff <= bad_in; sh_ff <= sh_in;
      out_value_ff <= out_value_in; out_bad_ff <= out_bad_in;
   end
endmodule
`default_nettype wire

// ===== sv/ggm_prf_eval_core.sv =====
// GGM tree PRF core. Each request carries a point; the core walks tree_depth levels
// from the root key, one AES-128 round per cycle with the key schedule run
// alongside; a left child takes one encryption and a right child two. It then
// scans up to 64 windows of the leaf at one per cycle. A bad point skips the
// walk and the scan. A two-entry queue lets the next request be accepted while
// one is being walked.
`default_nettype none
module ggm_prf_eval_core #(
   parameter int unsigned MAX_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_point,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_prf_value,
   output logic             rsp_bad_point,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import ggm_pkg::*;

   logic [63:0] key_hi_ff, key_lo_ff;
   logic [5:0]  depth_ff;
   logic [31:0] limit_ff;
   logic        job_valid, job_ready;
   job_type     job;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0; key_lo_ff <= '0;
         depth_ff <= 6'd16; limit_ff <= 32'd65536;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_hi_ff <= csr_data;
            CSR_KEY_LOW:  key_lo_ff <= csr_data;
            CSR_DEPTH:    depth_ff <= csr_data[5:0];
            CSR_LIMIT:    limit_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   ggm_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_point,
      .depth_cfg(depth_ff), .job_valid, .job_ready, .job
   );

   ggm_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .root_key({key_hi_ff, key_lo_ff}), .limit_cfg(limit_ff),
      .rsp_valid, .rsp_ready, .rsp_prf_value, .rsp_bad_point
   );
endmodule
`default_nettype wire

// ===== sv/ggm_prf_eval_core_checker.sv =====
`default_nettype none
`include "ggm_prf_eval_core_defines.svh"
module ggm_prf_eval_core_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_prf_value,
   input wire logic        rsp_bad_point
);
   // Hold a stalled response
   `GGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   // Flag a bad point only with a zero value
   `GGM_ASSERT_IMP(a_bad_zero, clock, reset, rsp_valid && rsp_bad_point, rsp_prf_value == 32'd0, "bad point value")
   // Keep the response value stable while stalled
   `GGM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_prf_value), "value changed")
endmodule
bind ggm_prf_eval_core ggm_prf_eval_core_checker u_chk (.*);
`default_nettype wire
